// File: design/vdi_pkg.sv
package vdi_pkg;

    // Table geometry
    localparam int TABLE_DEPTH = 1024;
    localparam int INDEX_BITS  = 16;
    localparam int NUM_CELLS   = 8;
    localparam int CELL_BITS   = $clog2(NUM_CELLS);
    localparam int SLOT_W      = $clog2(TABLE_DEPTH);
    localparam int COUNT_W     = $clog2(TABLE_DEPTH + 1);
    localparam int ROW_DEPTH   = TABLE_DEPTH / NUM_CELLS;
    localparam int ROW_W       = SLOT_W - CELL_BITS;
    localparam int ROW_CNT_W   = COUNT_W + 1 - CELL_BITS;
    localparam int KEY_W       = 3 * INDEX_BITS;

    // Float bounds for an empty box
    localparam logic [31:0] FLT_LARGEST = 32'h7F7F_FFFF;
    localparam logic [31:0] FLT_LOWEST  = 32'hFF7F_FFFF;

    // Search token handed from cell to cell
    typedef struct packed {
        logic              valid;
        logic [ROW_W-1:0]  row;
        logic              hit;
        logic [SLOT_W-1:0] slot;
    } token_t;

    // Insert request broadcast to every cell
    typedef struct packed {
        logic                 en;
        logic [CELL_BITS-1:0] bank;
        logic [ROW_W-1:0]     row;
        logic [KEY_W-1:0]     key;
    } write_req_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } state_t;

    // Map IEEE single bits onto an unsigned order
    function automatic logic [31:0] order_key(input logic [31:0] f);
        return f[31] ? ~f : (f | 32'h8000_0000);
    endfunction

endpackage

// File: design/vdi_ram.sv
module vdi_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: design/vdi_cell.sv
module vdi_cell
    import vdi_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [CELL_BITS-1:0] cell_id,
    input  logic [KEY_W-1:0]     key,
    input  logic [COUNT_W-1:0]   count,
    input  write_req_t           wr,
    input  token_t               tok_in,
    output token_t               tok_out
);

    token_t            tok_reg;
    logic [KEY_W-1:0]  rdata;
    logic [SLOT_W-1:0] slot;
    logic              slot_ok;
    logic              own_hit;

    // Bank of keys for every slot whose low bits equal this cell's id
    vdi_ram #(
        .WIDTH (KEY_W),
        .DEPTH (ROW_DEPTH)
    ) u_bank (
        .clk   (clk),
        .we    (wr.en && (wr.bank == cell_id)),
        .waddr (wr.row),
        .wdata (wr.key),
        .raddr (tok_in.row),
        .rdata (rdata)
    );

    // Hold the token while the bank read completes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= '0;
        end
        else
        begin
            tok_reg <= tok_in;
        end
    end

    // Compare against this slot if it lies below the fill count
    assign slot    = {tok_reg.row, cell_id};
    assign slot_ok = COUNT_W'(slot) < count;
    assign own_hit = tok_reg.valid && slot_ok && (rdata == key);

    // Merge with the hit carried in from the left
    always_comb
    begin
        tok_out       = tok_reg;
        tok_out.hit   = tok_reg.hit || own_hit;
        tok_out.slot  = tok_reg.hit ? tok_reg.slot : slot;
    end

endmodule

// File: design/vertex_dedup_indexer_top.sv
// A request is taken only in ST_IDLE, so one corner is searched at a time; a finished
// search writes its result once the previous result has been taken on out_ready.
// The search runs the stored rows through the eight-cell search chain, which reads
// one row of eight key slots per cycle.
// Reset clears the fill count, bounding box, control and output valid; the key
// banks are not cleared, the fill count masks unwritten slots.
module vertex_dedup_indexer_top
    import vdi_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        start_mesh,
    input  logic [15:0] pos_index,
    input  logic [15:0] normal_index,
    input  logic [15:0] uv_index,
    input  logic [31:0] pos_x,
    input  logic [31:0] pos_y,
    input  logic [31:0] pos_z,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [9:0]  vertex_index,
    output logic        is_new,
    output logic        overflow,
    output logic [10:0] unique_count,
    output logic [31:0] min_x,
    output logic [31:0] min_y,
    output logic [31:0] min_z,
    output logic [31:0] max_x,
    output logic [31:0] max_y,
    output logic [31:0] max_z
);

    state_t                 state_reg, state_next;
    logic [COUNT_W-1:0]     count_reg, count_next;
    logic [31:0]            box_min_reg [3];
    logic [31:0]            box_min_next [3];
    logic [31:0]            box_max_reg [3];
    logic [31:0]            box_max_next [3];
    logic [ROW_CNT_W-1:0]   issue_reg, issue_next;
    logic [ROW_CNT_W-1:0]   ret_reg, ret_next;
    logic                   hit_reg, hit_next;
    logic [SLOT_W-1:0]      hit_slot_reg, hit_slot_next;
    logic                   out_valid_reg, out_valid_next;

    logic [KEY_W-1:0]       key_reg, key_next;
    logic [31:0]            pos_reg [3];
    logic [31:0]            pos_next [3];
    logic [9:0]             vidx_reg, vidx_next;
    logic                   new_reg, new_next;
    logic                   ovf_reg, ovf_next;
    logic [10:0]            ucnt_reg, ucnt_next;
    logic [31:0]            omin_reg [3];
    logic [31:0]            omin_next [3];
    logic [31:0]            omax_reg [3];
    logic [31:0]            omax_next [3];

    logic [COUNT_W:0]       round_up;
    logic [ROW_CNT_W-1:0]   rows_total;
    logic                   full;
    write_req_t             wr;
    token_t                 chain [NUM_CELLS+1];

    // Rows of eight slots that hold stored keys
    assign round_up   = {1'b0, count_reg} + (COUNT_W+1)'(NUM_CELLS - 1);
    assign rows_total = round_up[COUNT_W:CELL_BITS];
    assign full       = (count_reg == COUNT_W'(TABLE_DEPTH));

    // Feed one row per cycle into the head of the chain
    always_comb
    begin
        chain[0]       = '0;
        chain[0].valid = (state_reg == ST_SCAN) && (issue_reg < rows_total);
        chain[0].row   = issue_reg[ROW_W-1:0];
    end

    // Search chain
    for (genvar i = 0; i < NUM_CELLS; i++)
    begin : g_cell
        vdi_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .cell_id (CELL_BITS'(i)),
            .key     (key_reg),
            .count   (count_reg),
            .wr      (wr),
            .tok_in  (chain[i]),
            .tok_out (chain[i+1])
        );
    end

    // Next state, search bookkeeping and result
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        issue_next     = issue_reg;
        ret_next       = ret_reg;
        hit_next       = hit_reg;
        hit_slot_next  = hit_slot_reg;
        out_valid_next = out_valid_reg;
        key_next       = key_reg;
        vidx_next      = vidx_reg;
        new_next       = new_reg;
        ovf_next       = ovf_reg;
        ucnt_next      = ucnt_reg;
        for (int c = 0; c < 3; c++)
        begin
            box_min_next[c] = box_min_reg[c];
            box_max_next[c] = box_max_reg[c];
            pos_next[c]     = pos_reg[c];
            omin_next[c]    = omin_reg[c];
            omax_next[c]    = omax_reg[c];
        end
        wr       = '0;
        wr.bank  = count_reg[CELL_BITS-1:0];
        wr.row   = count_reg[SLOT_W-1:CELL_BITS];
        wr.key   = key_reg;
        in_ready = 1'b0;

        // Drop the result once taken
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    key_next    = {uv_index[INDEX_BITS-1:0],
                                   normal_index[INDEX_BITS-1:0],
                                   pos_index[INDEX_BITS-1:0]};
                    pos_next[0] = pos_x;
                    pos_next[1] = pos_y;
                    pos_next[2] = pos_z;
                    if (start_mesh)
                    begin
                        count_next = '0;
                        for (int c = 0; c < 3; c++)
                        begin
                            box_min_next[c] = FLT_LARGEST;
                            box_max_next[c] = FLT_LOWEST;
                        end
                    end
                    issue_next = '0;
                    ret_next   = '0;
                    hit_next   = 1'b0;
                    state_next = ST_SCAN;
                end
            end

            ST_SCAN:
            begin
                if (chain[0].valid)
                begin
                    issue_next = issue_reg + 1'b1;
                end
                if (chain[NUM_CELLS].valid)
                begin
                    ret_next = ret_reg + 1'b1;
                    if (chain[NUM_CELLS].hit)
                    begin
                        hit_next      = 1'b1;
                        hit_slot_next = chain[NUM_CELLS].slot;
                    end
                end
                if (ret_reg == rows_total)
                begin
                    state_next = ST_FINISH;
                end
            end

            ST_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    if (hit_reg)
                    begin
                        vidx_next = 10'(hit_slot_reg);
                        new_next  = 1'b0;
                        ovf_next  = 1'b0;
                    end
                    else if (full)
                    begin
                        vidx_next = '0;
                        new_next  = 1'b0;
                        ovf_next  = 1'b1;
                    end
                    else
                    begin
                        // Insert the key and widen the box
                        wr.en      = 1'b1;
                        vidx_next  = 10'(count_reg);
                        new_next   = 1'b1;
                        ovf_next   = 1'b0;
                        count_next = count_reg + 1'b1;
                        for (int c = 0; c < 3; c++)
                        begin
                            if (order_key(pos_reg[c]) > order_key(box_max_reg[c]))
                            begin
                                box_max_next[c] = pos_reg[c];
                            end
                            if (order_key(pos_reg[c]) < order_key(box_min_reg[c]))
                            begin
                                box_min_next[c] = pos_reg[c];
                            end
                        end
                    end
                    ucnt_next = 11'(count_next);
                    for (int c = 0; c < 3; c++)
                    begin
                        omin_next[c] = box_min_next[c];
                        omax_next[c] = box_max_next[c];
                    end
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            issue_reg     <= '0;
            ret_reg       <= '0;
            hit_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int c = 0; c < 3; c++)
            begin
                box_min_reg[c] <= FLT_LARGEST;
                box_max_reg[c] <= FLT_LOWEST;
            end
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            issue_reg     <= issue_next;
            ret_reg       <= ret_next;
            hit_reg       <= hit_next;
            out_valid_reg <= out_valid_next;
            for (int c = 0; c < 3; c++)
            begin
                box_min_reg[c] <= box_min_next[c];
                box_max_reg[c] <= box_max_next[c];
            end
        end
    end

    // Request payload and result payload
    always_ff @(posedge clk)
    begin
        key_reg      <= key_next;
        hit_slot_reg <= hit_slot_next;
        vidx_reg     <= vidx_next;
        new_reg      <= new_next;
        ovf_reg      <= ovf_next;
        ucnt_reg     <= ucnt_next;
        for (int c = 0; c < 3; c++)
        begin
            pos_reg[c]  <= pos_next[c];
            omin_reg[c] <= omin_next[c];
            omax_reg[c] <= omax_next[c];
        end
    end

    assign out_valid    = out_valid_reg;
    assign vertex_index = vidx_reg;
    assign is_new       = new_reg;
    assign overflow     = ovf_reg;
    assign unique_count = ucnt_reg;
    assign min_x        = omin_reg[0];
    assign min_y        = omin_reg[1];
    assign min_z        = omin_reg[2];
    assign max_x        = omax_reg[0];
    assign max_y        = omax_reg[1];
    assign max_z        = omax_reg[2];

endmodule

// File: design/vdi_checker.sv
module vdi_checker
    import vdi_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [9:0]  vertex_index,
    input logic        is_new,
    input logic        overflow,
    input logic [10:0] unique_count
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(vertex_index)
                                    && $stable(unique_count))
        else $error("stalled result changed");

    // A request is taken one at a time
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("request accepted while busy");

    // A new vertex takes the last assigned index
    a_new_index: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && is_new |-> vertex_index == 10'(unique_count - 11'd1)
                                && !overflow)
        else $error("new vertex index does not match count");

    // Overflow only with a full table
    a_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && overflow |-> unique_count == 11'(TABLE_DEPTH)
                                  && vertex_index == 10'd0)
        else $error("overflow without a full table");

endmodule

bind vertex_dedup_indexer_top vdi_checker u_vdi_checker (.*);

// File: bench/vertex_dedup_indexer_top_tb.sv
module vertex_dedup_indexer_top_tb
    import vdi_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // Float bit patterns used by the directed rows
    localparam logic [31:0] F_PZERO   = 32'h0000_0000;
    localparam logic [31:0] F_NZERO   = 32'h8000_0000;
    localparam logic [31:0] F_ONE     = 32'h3F80_0000;
    localparam logic [31:0] F_MONE    = 32'hBF80_0000;
    localparam logic [31:0] F_PINF    = 32'h7F80_0000;
    localparam logic [31:0] F_NINF    = 32'hFF80_0000;
    localparam logic [31:0] F_QNAN    = 32'h7FC0_0000;
    localparam logic [31:0] F_NNAN    = 32'hFFC0_0000;
    localparam logic [31:0] F_MIN_DEN = 32'h0000_0001;

    localparam logic [15:0] IDX_MASK = 16'((64'd1 << INDEX_BITS) - 64'd1);
    localparam int N_DIR      = 17;
    localparam int HOLD_OFF   = 400;
    localparam int DRAIN_WAIT = 200;

    typedef struct packed {
        logic        start;
        logic [15:0] p_idx;
        logic [15:0] n_idx;
        logic [15:0] uv_idx;
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
    } corner_t;

    typedef struct packed {
        logic [9:0]  vidx;
        logic        fresh;
        logic        ovf;
        logic [10:0] count;
        logic [31:0] mnx;
        logic [31:0] mny;
        logic [31:0] mnz;
        logic [31:0] mxx;
        logic [31:0] mxy;
        logic [31:0] mxz;
    } vtx_result_t;

    typedef struct packed {
        logic        known;
        corner_t     c;
        vtx_result_t r;
    } dir_row_t;

    localparam vtx_result_t NO_RESULT = '0;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic        start_mesh = 1'b0;
    logic [15:0] pos_index = '0;
    logic [15:0] normal_index = '0;
    logic [15:0] uv_index = '0;
    logic [31:0] pos_x = '0;
    logic [31:0] pos_y = '0;
    logic [31:0] pos_z = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [9:0]  vertex_index;
    logic        is_new;
    logic        overflow;
    logic [10:0] unique_count;
    logic [31:0] min_x;
    logic [31:0] min_y;
    logic [31:0] min_z;
    logic [31:0] max_x;
    logic [31:0] max_y;
    logic [31:0] max_z;

    // Welding state mirrored by the testbench
    logic [KEY_W-1:0] known_keys [TABLE_DEPTH];
    int               vertex_count;
    logic [31:0]      box_lo [3];
    logic [31:0]      box_hi [3];

    vtx_result_t awaited_vertices [$];
    dir_row_t    dir_rows [N_DIR];

    int mismatches = 0;
    int corners_sent = 0;
    int welds_new = 0;
    int welds_hit = 0;
    int welds_full = 0;
    int mesh_starts = 0;
    int peak_fill = 0;
    int send_quiet = 0;

    vertex_dedup_indexer_top DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .start_mesh   (start_mesh),
        .pos_index    (pos_index),
        .normal_index (normal_index),
        .uv_index     (uv_index),
        .pos_x        (pos_x),
        .pos_y        (pos_y),
        .pos_z        (pos_z),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .vertex_index (vertex_index),
        .is_new       (is_new),
        .overflow     (overflow),
        .unique_count (unique_count),
        .min_x        (min_x),
        .min_y        (min_y),
        .min_z        (min_z),
        .max_x        (max_x),
        .max_y        (max_y),
        .max_z        (max_z)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Sign-magnitude float bits onto an unsigned scale
    function automatic logic [31:0] float_rank(input logic [31:0] f);
        return f[31] ? ~f : {1'b1, f[30:0]};
    endfunction

    function automatic void clear_mesh();
        int ax;
        vertex_count = 0;
        for (ax = 0; ax < 3; ax++)
        begin
            box_lo[ax] = FLT_LARGEST;
            box_hi[ax] = FLT_LOWEST;
        end
    endfunction

    // Look the corner up, insert it on a miss while the table has room and widen the box
    function automatic vtx_result_t weld_corner(input corner_t c);
        vtx_result_t      r;
        logic [KEY_W-1:0] key;
        logic [31:0]      coord [3];
        int               slot;
        int               k;
        int               ax;
        if (c.start)
        begin
            clear_mesh();
            mesh_starts++;
        end
        key = {c.uv_idx & IDX_MASK, c.n_idx & IDX_MASK, c.p_idx & IDX_MASK};
        coord[0] = c.x;
        coord[1] = c.y;
        coord[2] = c.z;
        slot = -1;
        for (k = 0; k < vertex_count; k++)
        begin
            if (known_keys[k] == key)
            begin
                slot = k;
                break;
            end
        end
        r = '0;
        if (slot >= 0)
        begin
            r.vidx = 10'(slot);
            welds_hit++;
        end
        else if (vertex_count >= TABLE_DEPTH)
        begin
            r.ovf = 1'b1;
            welds_full++;
        end
        else
        begin
            known_keys[vertex_count] = key;
            r.vidx = 10'(vertex_count);
            r.fresh = 1'b1;
            vertex_count++;
            welds_new++;
            for (ax = 0; ax < 3; ax++)
            begin
                if (float_rank(coord[ax]) > float_rank(box_hi[ax]))
                    box_hi[ax] = coord[ax];
                if (float_rank(coord[ax]) < float_rank(box_lo[ax]))
                    box_lo[ax] = coord[ax];
            end
        end
        if (vertex_count > peak_fill)
            peak_fill = vertex_count;
        r.count = 11'(vertex_count);
        r.mnx = box_lo[0];
        r.mny = box_lo[1];
        r.mnz = box_lo[2];
        r.mxx = box_hi[0];
        r.mxy = box_hi[1];
        r.mxz = box_hi[2];
        return r;
    endfunction

    // Idle cycles before the next request, with runs of back-to-back traffic
    function automatic int draw_gap(inout int quiet_left);
        if (quiet_left > 0)
        begin
            quiet_left--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0)
        begin
            quiet_left = $urandom_range(8, 40);
            return 0;
        end
        return $urandom_range(0, 12);
    endfunction

    function automatic corner_t corner(input logic s, input logic [15:0] p, n, u,
                                       input logic [31:0] x, y, z);
        return {s, p, n, u, x, y, z};
    endfunction

    function automatic vtx_result_t result(input logic [9:0] v, input logic nw, ov,
                                           input logic [10:0] cnt,
                                           input logic [31:0] lx, ly, lz, hx, hy, hz);
        return {v, nw, ov, cnt, lx, ly, lz, hx, hy, hz};
    endfunction

    // Mostly plausible magnitudes, with raw bit patterns and specials mixed in
    function automatic logic [31:0] rand_coord();
        logic [31:0] f;
        f = $urandom();
        case ($urandom_range(0, 7))
            0: ;
            1:
            begin
                case ($urandom_range(0, 5))
                    0: f = F_PZERO;
                    1: f = F_NZERO;
                    2: f = F_PINF;
                    3: f = F_NINF;
                    4: f = FLT_LARGEST;
                    default: f = FLT_LOWEST;
                endcase
            end
            default: f[30:23] = 8'($urandom_range(112, 142));
        endcase
        return f;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want, got);
        if (got !== want)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endfunction

    // Offer one corner request and hold it until taken
    task automatic offer_corner(input corner_t c, input logic known, input vtx_result_t typed);
        int          gap;
        vtx_result_t pred;
        gap = draw_gap(send_quiet);
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid     <= 1'b1;
        start_mesh   <= c.start;
        pos_index    <= c.p_idx;
        normal_index <= c.n_idx;
        uv_index     <= c.uv_idx;
        pos_x        <= c.x;
        pos_y        <= c.y;
        pos_z        <= c.z;
        do @(posedge clk); while (!in_ready);
        pred = weld_corner(c);
        awaited_vertices.insert(awaited_vertices.size(), known ? typed : pred);
        corners_sent++;
    endtask

    // One mesh: a start corner then a mix of reused and fresh triples.
    // In fill mode keep inserting until the table is full, then spill past it.
    task automatic run_mesh(input int corners, input logic fill_up);
        corner_t c;
        int      i;
        int      spill;
        int      serial;
        int      reuse_pct;
        i = 0;
        spill = 0;
        serial = 1;
        while (fill_up ? (vertex_count < TABLE_DEPTH || spill < 60) : (i < corners))
        begin
            if (fill_up && vertex_count >= TABLE_DEPTH)
                spill++;
            c.start = (i == 0) || (!fill_up && $urandom_range(0, 99) == 0);
            if (!fill_up)
                reuse_pct = 50;
            else if (vertex_count >= TABLE_DEPTH)
                reuse_pct = 40;
            else
                reuse_pct = 8;
            if (i > 0 && vertex_count > 0 && $urandom_range(0, 99) < reuse_pct)
            begin
                {c.uv_idx, c.n_idx, c.p_idx} = known_keys[$urandom_range(0, vertex_count - 1)];
            end
            else if (fill_up)
            begin
                c.p_idx  = 16'(serial);
                c.n_idx  = 16'($urandom());
                c.uv_idx = 16'($urandom());
                serial++;
            end
            else if ($urandom_range(0, 1) == 1)
            begin
                c.p_idx  = 16'($urandom_range(0, 24));
                c.n_idx  = 16'($urandom_range(0, 24));
                c.uv_idx = 16'($urandom_range(0, 24));
            end
            else
            begin
                c.p_idx  = 16'($urandom());
                c.n_idx  = 16'($urandom());
                c.uv_idx = 16'($urandom());
            end
            c.x = rand_coord();
            c.y = rand_coord();
            c.z = rand_coord();
            offer_corner(c, 1'b0, NO_RESULT);
            i++;
        end
    endtask

    // Drain results, stalling at random and once or twice for a long stretch
    initial
    begin : result_sink
        int          gap;
        int          taken;
        int          quiet;
        vtx_result_t got;
        vtx_result_t want;
        taken = 0;
        quiet = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (taken == 40 || taken == 700)
                gap = HOLD_OFF;
            else
                gap = draw_gap(quiet);
            @(negedge clk);
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
            got = {vertex_index, is_new, overflow, unique_count,
                   min_x, min_y, min_z, max_x, max_y, max_z};
            taken++;
            if (awaited_vertices.size() == 0)
            begin
                $error("unexpected result: vertex_index %0h unique_count %0h",
                       got.vidx, got.count);
                mismatches++;
            end
            else
            begin
                want = awaited_vertices.pop_front();
                check_field("vertex_index", 32'(want.vidx), 32'(got.vidx));
                check_field("is_new", 32'(want.fresh), 32'(got.fresh));
                check_field("overflow", 32'(want.ovf), 32'(got.ovf));
                check_field("unique_count", 32'(want.count), 32'(got.count));
                check_field("min_x", want.mnx, got.mnx);
                check_field("min_y", want.mny, got.mny);
                check_field("min_z", want.mnz, got.mnz);
                check_field("max_x", want.mxx, got.mxx);
                check_field("max_y", want.mxy, got.mxy);
                check_field("max_z", want.mxz, got.mxz);
            end
        end
    end

    initial
    begin : watchdog
        #2_000_000;
        $display("Regression FAIL");
        $finish;
    end

    initial
    begin : stimulus
        int row;

        // Hit after insert, zero and all-ones indices, signed zeros, infinities,
        // NaNs, denormals, mesh restart with a previously stored triple
        dir_rows[0]  = {1'b1, corner(1'b0, 16'd1, 16'd1, 16'd1, F_ONE, F_MONE, F_PZERO),
                        result(10'd0, 1'b1, 1'b0, 11'd1, F_ONE, F_MONE, F_PZERO,
                               F_ONE, F_MONE, F_PZERO)};
        dir_rows[1]  = {1'b1, corner(1'b0, 16'd1, 16'd1, 16'd1, F_PINF, F_NINF, F_ONE),
                        result(10'd0, 1'b0, 1'b0, 11'd1, F_ONE, F_MONE, F_PZERO,
                               F_ONE, F_MONE, F_PZERO)};
        dir_rows[2]  = {1'b0, corner(1'b0, 16'd0, 16'd0, 16'd0, F_NZERO, F_PZERO, F_NZERO),
                        NO_RESULT};
        dir_rows[3]  = {1'b0, corner(1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                                     F_PINF, F_NINF, FLT_LARGEST), NO_RESULT};
        dir_rows[4]  = {1'b0, corner(1'b0, 16'hFFFF, 16'd0, 16'd0,
                                     FLT_LOWEST, FLT_LARGEST, F_MIN_DEN), NO_RESULT};
        dir_rows[5]  = {1'b0, corner(1'b0, 16'd0, 16'hFFFF, 16'd0,
                                     F_QNAN, F_NNAN, 32'hFFFF_FFFF), NO_RESULT};
        dir_rows[6]  = {1'b0, corner(1'b0, 16'd0, 16'd0, 16'hFFFF,
                                     32'h7FFF_FFFF, 32'h8000_0001, F_NINF), NO_RESULT};
        dir_rows[7]  = {1'b0, corner(1'b0, 16'd1, 16'd1, 16'd2, F_ONE, F_MONE, F_PZERO),
                        NO_RESULT};
        dir_rows[8]  = {1'b0, corner(1'b0, 16'd0, 16'd0, 16'd0, F_ONE, F_ONE, F_ONE),
                        NO_RESULT};
        dir_rows[9]  = {1'b0, corner(1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF, F_ONE, F_ONE, F_ONE),
                        NO_RESULT};
        // A positive NaN ranks above the largest float, so the minimum keeps its start
        dir_rows[10] = {1'b1, corner(1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                                     32'h7FFF_FFFF, 32'h8000_0001, F_MIN_DEN),
                        result(10'd0, 1'b1, 1'b0, 11'd1, FLT_LARGEST, 32'h8000_0001,
                               F_MIN_DEN, 32'h7FFF_FFFF, 32'h8000_0001, F_MIN_DEN)};
        dir_rows[11] = {1'b0, corner(1'b0, 16'd1, 16'd1, 16'd1, F_MONE, F_ONE, F_NZERO),
                        NO_RESULT};
        dir_rows[12] = {1'b1, corner(1'b1, 16'd1, 16'd1, 16'd1, F_ONE, F_ONE, F_ONE),
                        result(10'd0, 1'b1, 1'b0, 11'd1, F_ONE, F_ONE, F_ONE,
                               F_ONE, F_ONE, F_ONE)};
        dir_rows[13] = dir_rows[12];
        dir_rows[14] = {1'b0, corner(1'b0, 16'h5555, 16'hAAAA, 16'h5555,
                                     32'hAAAA_5555, 32'h5555_AAAA, 32'h1234_5678), NO_RESULT};
        dir_rows[15] = {1'b0, corner(1'b0, 16'hAAAA, 16'h5555, 16'hAAAA,
                                     32'h5555_AAAA, 32'hAAAA_5555, 32'hEDCB_A987), NO_RESULT};
        dir_rows[16] = {1'b0, corner(1'b0, 16'd1, 16'd1, 16'd1, F_PZERO, F_PZERO, F_PZERO),
                        NO_RESULT};

        // Hold reset, then release away from the rising edge
        clear_mesh();
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (row = 0; row < N_DIR; row++)
            offer_corner(dir_rows[row].c, dir_rows[row].known, dir_rows[row].r);

        // Small meshes, one mesh that fills the table and spills, then small again
        while (corners_sent < 280)
            run_mesh($urandom_range(4, 40), 1'b0);
        run_mesh(0, 1'b1);
        while (corners_sent < 1650)
            run_mesh($urandom_range(4, 40), 1'b0);

        @(negedge clk);
        in_valid <= 1'b0;

        // Wait out the outstanding results, then the search latency of a full table
        while (awaited_vertices.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        $display("Sent %0d corners in %0d meshes: %0d inserted, %0d reused, %0d refused full",
                 corners_sent, mesh_starts, welds_new, welds_hit, welds_full);
        $display("Largest table fill %0d of %0d slots, %0d mismatches",
                 peak_fill, TABLE_DEPTH, mismatches);
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// File: sim.f
design/vdi_pkg.sv
design/vdi_ram.sv
design/vdi_cell.sv
design/vertex_dedup_indexer_top.sv
design/vdi_checker.sv
bench/vertex_dedup_indexer_top_tb.sv
